// ----- rtl/core/bliir_pkg.sv -----
package bliir_pkg;

   localparam int MAX_BLOCK_WIDTH_DEF  = 64;
   localparam int FEEDFORWARD_TAPS_DEF = 16;
   localparam int FEEDBACK_TAPS_DEF    = 16;
   localparam int SAMPLE_BITS_DEF      = 16;

   localparam int ADDR_SPAN  = 16;
   localparam int COEF_BITS  = 16;
   localparam int ACC_BITS   = 48;
   localparam int PROD_BITS  = 80;
   localparam int CSR_IDX_BITS = 3;
   localparam logic [31:0] ONE_Q14 = 32'd16384;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_WIDTH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIR_LEN     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IIR_LEN     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_ADDR   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_VALUE  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NORM_INV    = 3'd5;

   typedef struct packed {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] result_re;
      logic signed [15:0] result_im;
      logic               block_end;
      logic               saturated;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRITE_X, ST_RD_FF, ST_MAC_FF, ST_RD_FB, ST_MAC_FB,
      ST_NORM_A, ST_NORM_B, ST_NORM_C, ST_ROUND, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;    // write zero at clr_ff
      logic clear_reset;   // zero accumulators
      logic write_x;       // store the request sample
      logic read_hist;     // issue history/coef read at tap
      logic read_fb;       // read from the feedback half of the table
      logic mac_ff;        // accumulate b*x
      logic mac_fb;        // subtract a*y
      logic norm_a;        // multiply phase 1
      logic norm_b;        // multiply phase 2
      logic norm_c;        // combine
      logic round;         // round and clip into result
      logic advance;       // write y, step lane/row
      logic [4:0] tap;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic unit_a0;
   } dp_stat_type;

endpackage

// ----- rtl/core/bliir_ctrl.sv -----
module bliir_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [4:0]             ff_taps,
   input  logic [4:0]             fb_taps,
   input  bliir_pkg::dp_stat_type stat,
   output bliir_pkg::dp_cmd_type  cmd
);
   import bliir_pkg::*;

   state_type state_ff, state_in;
   logic [4:0] tap_ff, tap_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // hold state, tap counter and response valid
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= ST_CLEAR;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // sequence one request through the shared multiply-accumulate
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.tap      = tap_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.write_x     = 1'b1;
               cmd.clear_reset = 1'b1;
               tap_in          = '0;
               state_in        = ST_RD_FF;
            end
         end
         ST_WRITE_X: state_in = ST_RD_FF;
         ST_RD_FF: begin
            cmd.read_hist = 1'b1;
            state_in      = ST_MAC_FF;
         end
         ST_MAC_FF: begin
            cmd.mac_ff = 1'b1;
            if (tap_ff + 5'd1 >= ff_taps) begin
               tap_in   = 5'd1;
               state_in = (fb_taps > 5'd1) ? ST_RD_FB : ST_NORM_A;
            end else begin
               tap_in   = tap_ff + 5'd1;
               state_in = ST_RD_FF;
            end
         end
         ST_RD_FB: begin
            cmd.read_hist = 1'b1;
            cmd.read_fb   = 1'b1;
            state_in      = ST_MAC_FB;
         end
         ST_MAC_FB: begin
            cmd.mac_fb = 1'b1;
            if (tap_ff + 5'd1 >= fb_taps) state_in = ST_NORM_A;
            else begin
               tap_in   = tap_ff + 5'd1;
               state_in = ST_RD_FB;
            end
         end
         ST_NORM_A: begin
            cmd.norm_a = !stat.unit_a0;
            state_in   = stat.unit_a0 ? ST_ROUND : ST_NORM_B;
         end
         ST_NORM_B: begin
            cmd.norm_b = 1'b1;
            state_in   = ST_NORM_C;
         end
         ST_NORM_C: begin
            cmd.norm_c = 1'b1;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.round    = 1'b1;
               cmd.advance  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/bliir_dpath.sv -----
module bliir_dpath #(
   parameter int MAX_BLOCK_WIDTH  = bliir_pkg::MAX_BLOCK_WIDTH_DEF,
   parameter int FEEDFORWARD_TAPS = bliir_pkg::FEEDFORWARD_TAPS_DEF,
   parameter int FEEDBACK_TAPS    = bliir_pkg::FEEDBACK_TAPS_DEF,
   parameter int SAMPLE_BITS      = bliir_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  bliir_pkg::dp_cmd_type      cmd,
   output bliir_pkg::dp_stat_type     stat,
   input  bliir_pkg::req_payload_type req_data,
   output bliir_pkg::rsp_payload_type rsp_data,
   input  logic [6:0]                 width_cfg,
   input  logic [31:0]                norm_inv,
   input  logic                       coef_we,
   input  logic [4:0]                 coef_waddr,
   input  logic [31:0]                coef_wdata
);
   import bliir_pkg::*;

   localparam int RING_ROWS  = (FEEDFORWARD_TAPS > FEEDBACK_TAPS) ? FEEDFORWARD_TAPS
                                                                  : FEEDBACK_TAPS;
   localparam int ROW_BITS   = (RING_ROWS > 1) ? $clog2(RING_ROWS) : 1;
   localparam int RS_BITS    = ROW_BITS + 2;
   localparam int LANE_BITS  = (MAX_BLOCK_WIDTH > 1) ? $clog2(MAX_BLOCK_WIDTH) : 1;
   localparam int HIST_DEPTH = RING_ROWS * MAX_BLOCK_WIDTH;
   localparam int HA_BITS    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CLIP_BITS  = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
   localparam logic signed [PROD_BITS-1:0] CLIP_HI = (PROD_BITS'(1) <<< (CLIP_BITS-1)) - 1;
   localparam logic signed [PROD_BITS-1:0] CLIP_LO = -CLIP_HI - 1;

   logic [31:0] xhist [HIST_DEPTH];
   logic [31:0] yhist [HIST_DEPTH];
   logic [31:0] coef_ff [2*ADDR_SPAN];

   logic [HA_BITS-1:0]   clr_ff;
   logic [LANE_BITS-1:0] lane_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic [31:0] xrd_ff, yrd_ff, crd_ff;
   logic signed [ACC_BITS-1:0]  acc_re_ff, acc_im_ff;
   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff, p3_ff, fin_re_ff, fin_im_ff;
   logic        unit_ff;
   rsp_payload_type rsp_ff;

   logic [6:0] eff_w;
   logic [RS_BITS-1:0]   row_sum;
   logic [ROW_BITS-1:0]  rd_row;
   logic [HA_BITS-1:0]   cur_addr, rd_addr;
   logic [4:0] caddr;
   logic signed [15:0] rsp_in_re, rsp_in_im;

   always_comb begin
      eff_w = width_cfg;
      if (eff_w == 7'd0) eff_w = 7'd1;
      if (32'(eff_w) > MAX_BLOCK_WIDTH) eff_w = 7'(MAX_BLOCK_WIDTH);
   end

   // step back tap rows around the ring
   assign row_sum  = RS_BITS'(row_ff) + RS_BITS'(RING_ROWS) - RS_BITS'(cmd.tap);
   assign rd_row   = (row_sum >= RS_BITS'(RING_ROWS)) ? ROW_BITS'(row_sum - RS_BITS'(RING_ROWS))
                                                       : ROW_BITS'(row_sum);
   assign cur_addr = HA_BITS'(row_ff) * HA_BITS'(MAX_BLOCK_WIDTH) + HA_BITS'(lane_ff);
   assign rd_addr  = HA_BITS'(rd_row) * HA_BITS'(MAX_BLOCK_WIDTH) + HA_BITS'(lane_ff);
   assign caddr    = cmd.read_fb ? 5'(ADDR_SPAN) + cmd.tap : cmd.tap;

   assign stat.clear_done = (clr_ff == HA_BITS'(HIST_DEPTH - 1));
   assign stat.unit_a0    = unit_ff;

   // coefficient table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2*ADDR_SPAN; i++) coef_ff[i] <= '0;
      end else if (coef_we) begin
         coef_ff[coef_waddr] <= coef_wdata;
      end
      unit_ff <= reset ? 1'b1 : ((coef_we && coef_waddr == 5'(ADDR_SPAN))
                 ? (coef_wdata == ONE_Q14) : (coef_ff[ADDR_SPAN] == ONE_Q14));
   end

   // clear sweep pointer
   always_ff @(posedge clock) begin
      if (reset || restart) clr_ff <= '0;
      else if (cmd.clear_step && !stat.clear_done) clr_ff <= clr_ff + 1'b1;
   end

   // history memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         xhist[clr_ff] <= '0;
      end else if (cmd.write_x) begin
         xhist[cur_addr] <= {req_data.sample_im, req_data.sample_re};
      end
      xrd_ff <= xhist[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         yhist[clr_ff] <= '0;
      end else if (cmd.advance) begin
         yhist[cur_addr] <= {rsp_in_im, rsp_in_re};
      end
      yrd_ff <= yhist[rd_addr];
   end

   // register the coefficient for the current tap
   always_ff @(posedge clock) begin
      if (cmd.read_hist) crd_ff <= coef_ff[caddr];
   end

   // complex multiply of the read operands
   logic signed [15:0] dr, di, cr, ci;
   logic signed [32:0] mre, mim;
   assign dr  = cmd.mac_fb ? yrd_ff[15:0]  : xrd_ff[15:0];
   assign di  = cmd.mac_fb ? yrd_ff[31:16] : xrd_ff[31:16];
   assign cr  = crd_ff[15:0];
   assign ci  = crd_ff[31:16];
   assign mre = 33'(dr * cr) - 33'(di * ci);
   assign mim = 33'(dr * ci) + 33'(di * cr);

   // accumulate; normalize in partial products
   logic signed [15:0] nr, ni;
   assign nr = norm_inv[15:0];
   assign ni = norm_inv[31:16];
   always_ff @(posedge clock) begin
      if (cmd.clear_reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (cmd.mac_ff) begin
         acc_re_ff <= acc_re_ff + ACC_BITS'(mre);
         acc_im_ff <= acc_im_ff + ACC_BITS'(mim);
      end else if (cmd.mac_fb) begin
         acc_re_ff <= acc_re_ff - ACC_BITS'(mre);
         acc_im_ff <= acc_im_ff - ACC_BITS'(mim);
      end
      if (cmd.norm_a) begin
         p0_ff <= PROD_BITS'(acc_re_ff) * PROD_BITS'(nr);
         p1_ff <= PROD_BITS'(acc_im_ff) * PROD_BITS'(ni);
      end
      if (cmd.norm_b) begin
         p2_ff <= PROD_BITS'(acc_re_ff) * PROD_BITS'(ni);
         p3_ff <= PROD_BITS'(acc_im_ff) * PROD_BITS'(nr);
      end
      if (cmd.norm_c) begin
         fin_re_ff <= p0_ff - p1_ff;
         fin_im_ff <= p2_ff + p3_ff;
      end
   end

   // round half up and clip
   logic signed [PROD_BITS-1:0] sr, si, rr, ri;
   logic clip_re, clip_im;
   always_comb begin
      if (unit_ff) begin
         sr = (PROD_BITS'(acc_re_ff) + PROD_BITS'(1 << 13)) >>> 14;
         si = (PROD_BITS'(acc_im_ff) + PROD_BITS'(1 << 13)) >>> 14;
      end else begin
         sr = (fin_re_ff + PROD_BITS'(1 << 27)) >>> 28;
         si = (fin_im_ff + PROD_BITS'(1 << 27)) >>> 28;
      end
      clip_re = (sr > CLIP_HI) || (sr < CLIP_LO);
      clip_im = (si > CLIP_HI) || (si < CLIP_LO);
      rr = (sr > CLIP_HI) ? CLIP_HI : ((sr < CLIP_LO) ? CLIP_LO : sr);
      ri = (si > CLIP_HI) ? CLIP_HI : ((si < CLIP_LO) ? CLIP_LO : si);
      rsp_in_re = rr[15:0];
      rsp_in_im = ri[15:0];
   end

   // result register and lane/row stepping
   logic last_lane;
   assign last_lane = (7'(lane_ff) + 7'd1 >= eff_w);
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         lane_ff <= '0;
         row_ff  <= '0;
      end else if (cmd.advance) begin
         if (last_lane) begin
            lane_ff <= '0;
            row_ff  <= (32'(row_ff) + 1 >= RING_ROWS) ? '0 : row_ff + 1'b1;
         end else begin
            lane_ff <= lane_ff + 1'b1;
         end
      end
      if (cmd.round) begin
         rsp_ff.result_re <= rsp_in_re;
         rsp_ff.result_im <= rsp_in_im;
         rsp_ff.block_end <= last_lane;
         rsp_ff.saturated <= clip_re || clip_im;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/block_lane_iir_filter_core.sv -----
// Block-lane complex IIR filter, direct form I.
// Requests carry one Q1.15 complex sample on req_valid/req_stall; each
// produces exactly one response on rsp_valid/rsp_stall with the filtered
// sample, a block_end flag for the last lane of a block and a saturated flag.
// Registers are written on the csr_ port (index, data); the user must write them
// only while idle, which the block does not enforce. Writing block_width, fir_len
// or iir_len clears both history memories. One request is handled at a time: a
// taken request reads and accumulates each feedforward tap, then each feedback
// tap after the first, then (when a0 is not 1.0) runs the reciprocal multiply,
// then rounds into the response register; the next request can be taken as soon
// as the response is raised. The single shared complex multiply-accumulate and
// the one read port of each history memory serialize the taps.
// Reset, and any geometry write, start a clearing pass over
// MAX_BLOCK_WIDTH*max(taps) history entries (1024 at defaults) with req_stall high.
// A stalled response holds its payload; the next request is taken while the
// previous result waits, but its result is not written until the old one
// leaves.
module block_lane_iir_filter_core #(
   parameter int MAX_BLOCK_WIDTH  = bliir_pkg::MAX_BLOCK_WIDTH_DEF,
   parameter int FEEDFORWARD_TAPS = bliir_pkg::FEEDFORWARD_TAPS_DEF,
   parameter int FEEDBACK_TAPS    = bliir_pkg::FEEDBACK_TAPS_DEF,
   parameter int SAMPLE_BITS      = bliir_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bliir_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bliir_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data
);
   import bliir_pkg::*;

   logic [6:0]  width_ff;
   logic [4:0]  fir_ff, iir_ff, caddr_ff, ff_taps, fb_taps;
   logic [31:0] norm_ff;
   logic        csr_we, restart;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign restart   = csr_we && (csr_index == CSR_BLOCK_WIDTH ||
                      csr_index == CSR_FIR_LEN || csr_index == CSR_IIR_LEN);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd1;
         fir_ff   <= 5'd1;
         iir_ff   <= 5'd1;
         caddr_ff <= '0;
         norm_ff  <= ONE_Q14;
      end else if (csr_we) begin
         if (csr_index == CSR_BLOCK_WIDTH) width_ff <= csr_data[6:0];
         if (csr_index == CSR_FIR_LEN)     fir_ff   <= csr_data[4:0];
         if (csr_index == CSR_IIR_LEN)     iir_ff   <= csr_data[4:0];
         if (csr_index == CSR_COEF_ADDR)   caddr_ff <= csr_data[4:0];
         if (csr_index == CSR_NORM_INV)    norm_ff  <= csr_data;
      end
   end

   // effective tap counts
   always_comb begin
      ff_taps = (fir_ff == 5'd0) ? 5'd1 : fir_ff;
      if (ff_taps > 5'(ADDR_SPAN)) ff_taps = 5'(ADDR_SPAN);
      if (32'(ff_taps) > FEEDFORWARD_TAPS) ff_taps = 5'(FEEDFORWARD_TAPS);
      fb_taps = (iir_ff == 5'd0) ? 5'd1 : iir_ff;
      if (fb_taps > 5'(ADDR_SPAN)) fb_taps = 5'(ADDR_SPAN);
      if (32'(fb_taps) > FEEDBACK_TAPS) fb_taps = 5'(FEEDBACK_TAPS);
   end

   bliir_ctrl u_ctrl (
      .clock, .reset, .restart, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .ff_taps, .fb_taps, .stat, .cmd
   );

   bliir_dpath #(
      .MAX_BLOCK_WIDTH(MAX_BLOCK_WIDTH), .FEEDFORWARD_TAPS(FEEDFORWARD_TAPS),
      .FEEDBACK_TAPS(FEEDBACK_TAPS), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dpath (
      .clock, .reset, .restart, .cmd, .stat, .req_data, .rsp_data,
      .width_cfg(width_ff), .norm_inv(norm_ff),
      .coef_we(csr_we && csr_index == CSR_COEF_VALUE),
      .coef_waddr(caddr_ff), .coef_wdata(csr_data)
   );

   // no response during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(restart) |-> !rsp_valid || !$past(rsp_valid) || $past(rsp_stall))
      else $error("response raised during clear");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && !restart |=> $stable(rsp_data) || !rsp_valid)
      else $error("stalled response changed");

endmodule
